// ===== design/dsbq_pkg.sv =====
// dsbq_pkg: shared types, microcode program and coefficient constants
`default_nettype none

package dsbq_pkg;

  // fixed formats of the internal values
  localparam int INT_W = 32;
  localparam int INT_FRAC = 16;
  localparam int MASTER_FRAC = 24;
  localparam int MASTER_W = 26;

  // defaults for the top level parameters
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COEF_FRAC_DEF = 16;

  // program counter
  localparam int PC_W = 5;

  // register addresses
  localparam logic REG_MODE = 1'b0;

  // coefficient indexes
  localparam logic [3:0] CI_B0  = 4'd0;
  localparam logic [3:0] CI_B1  = 4'd1;
  localparam logic [3:0] CI_B2  = 4'd2;
  localparam logic [3:0] CI_A1  = 4'd3;
  localparam logic [3:0] CI_A2  = 4'd4;
  localparam logic [3:0] CI_L0  = 4'd5;
  localparam logic [3:0] CI_L1  = 4'd6;
  localparam logic [3:0] CI_L2  = 4'd7;
  localparam logic [3:0] CI_LA1 = 4'd8;
  localparam logic [3:0] CI_LA2 = 4'd9;
  localparam logic [3:0] CI_G   = 4'd10;

  // control word fields
  typedef enum logic [1:0] {
    OP_X    = 2'd0,
    OP_BAND = 2'd1,
    OP_LIM  = 2'd2
  } op_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_LOAD = 2'd1,
    ACC_ADD  = 2'd2,
    ACC_SUB  = 2'd3
  } acc_op_t;

  typedef enum logic [2:0] {
    BASE_ZERO = 3'd0,
    BASE_D0   = 3'd1,
    BASE_D1   = 3'd2,
    BASE_D2   = 3'd3,
    BASE_D3   = 3'd4
  } base_sel_t;

  typedef enum logic [1:0] {
    SHF_SMP = 2'd0,
    SHF_INT = 2'd1,
    SHF_OUT = 2'd2
  } shift_sel_t;

  typedef enum logic [2:0] {
    DST_NONE = 3'd0,
    DST_BAND = 3'd1,
    DST_LIM  = 3'd2,
    DST_D0   = 3'd3,
    DST_D1   = 3'd4,
    DST_D2   = 3'd5,
    DST_D3   = 3'd6,
    DST_OUT  = 3'd7
  } dst_t;

  typedef enum logic [1:0] {
    JMP_NEXT     = 2'd0,
    JMP_WAIT_IN  = 2'd1,
    JMP_WAIT_OUT = 2'd2,
    JMP_RESTART  = 2'd3
  } jmp_t;

  typedef struct packed {
    op_sel_t    op;
    logic [3:0] coef_idx;
    acc_op_t    acc;
    base_sel_t  base;
    shift_sel_t shf;
    dst_t       dst;
    jmp_t       jmp;
  } ctrl_t;

  // sequencer to datapath command
  typedef struct packed {
    ctrl_t word;
    logic  idle;
    logic  take_in;
    logic  put_out;
  } seq_cmd_t;

  // microcode program: step 0 waits for a sample, steps 1 to 16 run the cascade
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{OP_X, CI_B0, ACC_HOLD, BASE_ZERO, SHF_INT, DST_NONE, JMP_NEXT};
    case (pc)
      5'd0: begin
        w.jmp = JMP_WAIT_IN;
      end
      5'd1: begin
        w.op = OP_X; w.coef_idx = CI_B0;
      end
      5'd2: begin
        w.op = OP_X; w.coef_idx = CI_B1;
        w.acc = ACC_LOAD; w.base = BASE_D0; w.shf = SHF_SMP;
      end
      5'd3: begin
        w.dst = DST_BAND;
        w.acc = ACC_LOAD; w.base = BASE_D1; w.shf = SHF_SMP;
      end
      5'd4: begin
        w.op = OP_BAND; w.coef_idx = CI_A1;
      end
      5'd5: begin
        w.acc = ACC_SUB; w.shf = SHF_INT;
      end
      5'd6: begin
        w.dst = DST_D0;
        w.op = OP_X; w.coef_idx = CI_B2;
      end
      5'd7: begin
        w.op = OP_BAND; w.coef_idx = CI_A2;
        w.acc = ACC_LOAD; w.base = BASE_ZERO; w.shf = SHF_SMP;
      end
      5'd8: begin
        w.op = OP_BAND; w.coef_idx = CI_L0;
        w.acc = ACC_SUB; w.shf = SHF_INT;
      end
      5'd9: begin
        w.dst = DST_D1;
        w.op = OP_BAND; w.coef_idx = CI_L1;
        w.acc = ACC_LOAD; w.base = BASE_D2; w.shf = SHF_INT;
      end
      5'd10: begin
        w.dst = DST_LIM;
        w.acc = ACC_LOAD; w.base = BASE_D3; w.shf = SHF_INT;
      end
      5'd11: begin
        w.op = OP_LIM; w.coef_idx = CI_LA1;
      end
      5'd12: begin
        w.op = OP_BAND; w.coef_idx = CI_L2;
        w.acc = ACC_SUB; w.shf = SHF_INT;
      end
      5'd13: begin
        w.dst = DST_D2;
        w.op = OP_LIM; w.coef_idx = CI_LA2;
        w.acc = ACC_LOAD; w.base = BASE_ZERO; w.shf = SHF_INT;
      end
      5'd14: begin
        w.op = OP_LIM; w.coef_idx = CI_G;
        w.acc = ACC_SUB; w.shf = SHF_INT;
      end
      5'd15: begin
        w.dst = DST_D3;
        w.acc = ACC_LOAD; w.base = BASE_ZERO; w.shf = SHF_OUT;
      end
      5'd16: begin
        w.dst = DST_OUT;
        w.jmp = JMP_WAIT_OUT;
      end
      default: begin
        w.jmp = JMP_RESTART;
      end
    endcase
    return w;
  endfunction

  // coefficients with 24 fraction bits, set 0 reference, set 1 hybrid
  function automatic logic signed [MASTER_W-1:0] coef_master(input logic sel,
                                                             input logic [3:0] idx);
    logic signed [MASTER_W-1:0] c;
    case ({sel, idx})
      5'h00: c = 26'sd24461592;
      5'h01: c = -26'sd9341267;
      5'h02: c = 26'sd4830443;
      5'h03: c = 26'sd294125;
      5'h04: c = 26'sd2879427;
      5'h05: c = 26'sd9968874;
      5'h06: c = 26'sd16770055;
      5'h07: c = 26'sd7239623;
      5'h08: c = 26'sd12615240;
      5'h09: c = 26'sd4586096;
      5'h0a: c = 26'sd14763950;
      5'h10: c = 26'sd21998149;
      5'h11: c = -26'sd5335177;
      5'h12: c = 26'sd4003445;
      5'h13: c = 26'sd1000144;
      5'h14: c = 26'sd2889056;
      5'h15: c = 26'sd14313279;
      5'h16: c = 26'sd22696777;
      5'h17: c = 26'sd9416472;
      5'h18: c = 26'sd21579987;
      5'h19: c = 26'sd8069325;
      5'h1a: c = 26'sd14092861;
      default: c = '0;
    endcase
    return c;
  endfunction

  // round half up to fewer fraction bits, used on constants only
  function automatic logic signed [MASTER_W-1:0] coef_round(
      input logic signed [MASTER_W-1:0] m, input int sh);
    logic signed [MASTER_W-1:0] half;
    half = '0;
    if (sh == 0) begin
      return m;
    end
    half = MASTER_W'(1) <<< (sh - 1);
    return (m + half) >>> sh;
  endfunction

endpackage

`default_nettype wire

// ===== design/dsbq_sequencer.sv =====
// dsbq_sequencer: step counter, microcode table and jump logic
`default_nettype none

module dsbq_sequencer
  import dsbq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  input  wire logic     out_free,
  output seq_cmd_t      cmd
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ctrl_t           word;

  // fetch the control word of this step
  assign word = ucode(pc);

  // next step
  always_comb begin
    pc_next = pc;
    case (word.jmp)
      JMP_NEXT: begin
        pc_next = PC_W'(pc + 1'b1);
      end
      JMP_WAIT_IN: begin
        if (in_valid) begin
          pc_next = PC_W'(pc + 1'b1);
        end
      end
      JMP_WAIT_OUT: begin
        if (out_free) begin
          pc_next = '0;
        end
      end
      JMP_RESTART: begin
        pc_next = '0;
      end
      default: begin
        pc_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

  // gate the output write of the word into put_out, which waits for a free output register
  always_comb begin
    cmd.word    = word;
    cmd.idle    = (word.jmp == JMP_WAIT_IN);
    cmd.take_in = (word.jmp == JMP_WAIT_IN) && in_valid;
    cmd.put_out = (word.dst == DST_OUT) && out_free;
    if (word.dst == DST_OUT) begin
      cmd.word.dst = DST_NONE;
    end
  end

endmodule

`default_nettype wire

// ===== design/dsbq_datapath.sv =====
// dsbq_datapath: shared multiplier, accumulator, delay registers and output register
`default_nettype none

module dsbq_datapath
  import dsbq_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           mode,
  input  wire seq_cmd_t                       cmd,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
  input  wire logic                           end_of_block,
  input  wire logic                           out_ready,
  output logic                                out_valid,
  output logic                                out_free,
  output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
  output logic                                end_of_block_out
);

  localparam int CW = COEF_FRAC_BITS + 2;
  localparam int PW = CW + INT_W;
  localparam int ACC_W = PW + 2;
  localparam int CSH = MASTER_FRAC - COEF_FRAC_BITS;
  localparam int SH_SMP = COEF_FRAC_BITS + SAMPLE_WIDTH - 1 - INT_FRAC;
  localparam int SH_INT = COEF_FRAC_BITS;
  localparam int SH_OUT = INT_FRAC + COEF_FRAC_BITS - (SAMPLE_WIDTH - 1);

  localparam logic signed [ACC_W-1:0] HALF_SMP = ACC_W'(1) <<< (SH_SMP - 1);
  localparam logic signed [ACC_W-1:0] HALF_INT = ACC_W'(1) <<< (SH_INT - 1);
  localparam logic signed [ACC_W-1:0] HALF_OUT = ACC_W'(1) <<< (SH_OUT - 1);
  localparam logic signed [ACC_W-1:0] INT_MAX = ACC_W'({1'b0, {(INT_W-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] INT_MIN = ~INT_MAX;
  localparam logic signed [ACC_W-1:0] OUT_MAX =
    ACC_W'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
  localparam logic signed [ACC_W-1:0] OUT_MIN = ~OUT_MAX;

  // constant coefficient table, rounded to the configured fraction bits
  logic signed [CW-1:0] coef_rom [32];

  for (genvar m = 0; m < 2; m++) begin : g_set
    for (genvar k = 0; k < 16; k++) begin : g_coef
      assign coef_rom[m*16+k] = CW'(coef_round(coef_master(1'(m), 4'(k)), CSH));
    end
  end

  logic signed [INT_W-1:0]        x_r;
  logic                           eob_r;
  logic signed [INT_W-1:0]        band;
  logic signed [INT_W-1:0]        lim;
  logic signed [INT_W-1:0]        dly [4];
  logic signed [PW-1:0]           prod;
  logic signed [ACC_W-1:0]        acc;
  logic signed [ACC_W-1:0]        acc_next;
  logic signed [CW-1:0]           coef_sel;
  logic signed [INT_W-1:0]        op_val;
  logic signed [PW-1:0]           prod_full;
  logic signed [ACC_W-1:0]        prod_ext;
  logic signed [ACC_W-1:0]        term;
  logic signed [ACC_W-1:0]        base_val;
  logic signed [INT_W-1:0]        sat_int;
  logic signed [SAMPLE_WIDTH-1:0] sat_smp;

  // capture the incoming sample
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      x_r   <= INT_W'(sample_in);
      eob_r <= end_of_block;
    end
  end

  // operand and coefficient selection
  assign coef_sel = coef_rom[{mode, cmd.word.coef_idx}];

  always_comb begin
    case (cmd.word.op)
      OP_X:    op_val = x_r;
      OP_BAND: op_val = band;
      OP_LIM:  op_val = lim;
      default: op_val = x_r;
    endcase
  end

  // shared multiplier, registered
  assign prod_full = coef_sel * op_val;

  always_ff @(posedge clk) begin
    prod <= prod_full;
  end

  // round the product half up to the target format
  assign prod_ext = ACC_W'(prod);

  always_comb begin
    case (cmd.word.shf)
      SHF_SMP: term = (prod_ext + HALF_SMP) >>> SH_SMP;
      SHF_INT: term = (prod_ext + HALF_INT) >>> SH_INT;
      SHF_OUT: term = (prod_ext + HALF_OUT) >>> SH_OUT;
      default: term = (prod_ext + HALF_INT) >>> SH_INT;
    endcase
  end

  // accumulator start value
  always_comb begin
    case (cmd.word.base)
      BASE_ZERO: base_val = '0;
      BASE_D0:   base_val = ACC_W'(dly[0]);
      BASE_D1:   base_val = ACC_W'(dly[1]);
      BASE_D2:   base_val = ACC_W'(dly[2]);
      BASE_D3:   base_val = ACC_W'(dly[3]);
      default:   base_val = '0;
    endcase
  end

  // accumulator
  always_comb begin
    case (cmd.word.acc)
      ACC_HOLD: acc_next = acc;
      ACC_LOAD: acc_next = base_val + term;
      ACC_ADD:  acc_next = acc + term;
      ACC_SUB:  acc_next = acc - term;
      default:  acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

  // saturation to the internal and the sample range
  always_comb begin
    if (acc > INT_MAX) begin
      sat_int = INT_W'(INT_MAX);
    end else if (acc < INT_MIN) begin
      sat_int = INT_W'(INT_MIN);
    end else begin
      sat_int = acc[INT_W-1:0];
    end
    if (acc > OUT_MAX) begin
      sat_smp = SAMPLE_WIDTH'(OUT_MAX);
    end else if (acc < OUT_MIN) begin
      sat_smp = SAMPLE_WIDTH'(OUT_MIN);
    end else begin
      sat_smp = acc[SAMPLE_WIDTH-1:0];
    end
  end

  // intermediate results
  always_ff @(posedge clk) begin
    case (cmd.word.dst)
      DST_BAND: band <= sat_int;
      DST_LIM:  lim <= sat_int;
      default: begin
      end
    endcase
  end

  // filter delays, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        dly[i] <= '0;
      end
    end else begin
      case (cmd.word.dst)
        DST_D0: dly[0] <= sat_int;
        DST_D1: dly[1] <= sat_int;
        DST_D2: dly[2] <= sat_int;
        DST_D3: dly[3] <= sat_int;
        default: begin
        end
      endcase
    end
  end

  // output register
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.put_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.put_out) begin
      sample_out       <= sat_smp;
      end_of_block_out <= eob_r;
    end
  end

endmodule

`default_nettype wire

// ===== design/dual_shelf_biquad_cascade_core.sv =====
// dual_shelf_biquad_cascade_core: top level, register port and filter core
//
//   channel   direction  handshake          payload
//   input     in         in_valid/in_ready  sample_in, end_of_block
//   output    out        out_valid/out_ready sample_out, end_of_block_out
//   config    in         psel/penable/pready paddr, pwdata, prdata (mode_select)
//
// one sample runs through 16 microcode steps from transfer to result, and the steps
// share one multiplier, eleven products in turn
// with the wait step in front, a new sample is taken only once the last one is done
// the next sample can be taken in the cycle in which the result first sits in the output register
// a result not taken holds the sequencer on its last step
// reset is synchronous; it clears the delays, the mode and the sequencer
`default_nettype none

module dual_shelf_biquad_cascade_core
  import dsbq_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [2:0]                     paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
  input  wire logic                           end_of_block,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
  output logic                                end_of_block_out
);

  logic     mode_select;
  logic     out_free;
  seq_cmd_t cmd;

  // register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_select <= 1'b0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_MODE)) begin
      mode_select <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_MODE) ? {31'b0, mode_select} : '0;

  // control
  dsbq_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_free (out_free),
    .cmd      (cmd)
  );

  assign in_ready = cmd.idle;

  // arithmetic
  dsbq_datapath #(
    .SAMPLE_WIDTH   (SAMPLE_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .mode             (mode_select),
    .cmd              (cmd),
    .sample_in        (sample_in),
    .end_of_block     (end_of_block),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_free         (out_free),
    .sample_out       (sample_out),
    .end_of_block_out (end_of_block_out)
  );

endmodule

`default_nettype wire

// ===== design/dsbq_checker.sv =====
// dsbq_checker: port-level assertions for the biquad cascade, bound to the top level
`default_nettype none

module dsbq_checker
  import dsbq_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [SAMPLE_WIDTH-1:0] sample_out,
  input wire logic                    end_of_block_out
);

  // nothing to show right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(sample_out) && $stable(end_of_block_out)))
    else $error("output changed before transfer");

  // one sample at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while busy");

  // a result needs the whole program
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> ##2 !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind dual_shelf_biquad_cascade_core dsbq_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_dsbq_checker (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .sample_out       (sample_out),
  .end_of_block_out (end_of_block_out)
);

`default_nettype wire
